>>> hdl/spfl_pkg.sv
// ----------------------------------------------------------------------------
// spfl_pkg
// Types and constants shared by the sensor plausibility check and fault latch.
// ----------------------------------------------------------------------------
package spfl_pkg;

	localparam int SAMPLE_W = 24;	// signed Q.8 sample width
	localparam int COUNT_W  = 8;	// bad run counter width
	localparam int LIMIT_W  = 23;	// window and step register width
	localparam int FCYC_W   = 8;	// fault_cycles register width
	localparam int REL_W    = 24;	// relative speed width
	localparam int PEDAL_W  = 8;
	localparam int STEER_W  = 16;
	localparam int CFG_IDX_W = 3;

	// signed working width, wide enough for a difference of two samples
	localparam int EXT_W = ((SAMPLE_W > LIMIT_W) ? SAMPLE_W : LIMIT_W) + 3;
	// width in which the counter is compared with fault_cycles
	localparam int CMP_W = (COUNT_W > FCYC_W) ? COUNT_W : FCYC_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIST_LO        = 3'd0,
		REG_DIST_HI        = 3'd1,
		REG_SPEED_MAX      = 3'd2,
		REG_DIST_STEP_MAX  = 3'd3,
		REG_SPEED_STEP_MAX = 3'd4,
		REG_FAULT_CYCLES   = 3'd5
	} spfl_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] distance;
		logic signed [SAMPLE_W-1:0] ego_speed;
		logic signed [SAMPLE_W-1:0] target_speed;
		logic [PEDAL_W-1:0]         pedal;
		logic signed [STEER_W-1:0]  steer;
	} spfl_sample_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] dist_lo;
		logic [LIMIT_W-1:0] dist_hi;
		logic [LIMIT_W-1:0] speed_max;
		logic [LIMIT_W-1:0] distance_step_max;
		logic [LIMIT_W-1:0] speed_step_max;
		logic [FCYC_W-1:0]  fault_cycles;
	} spfl_cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] last_distance;
		logic signed [SAMPLE_W-1:0] last_ego_speed;
		logic signed [SAMPLE_W-1:0] last_target_speed;
		logic                       first_sample;
	} spfl_hist_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]        distance;
		logic [LIMIT_W-1:0]        ego_speed;
		logic [LIMIT_W-1:0]        target_speed;
		logic signed [REL_W-1:0]   relative_speed;
		logic [PEDAL_W-1:0]        pedal;
		logic signed [STEER_W-1:0] steer;
		logic                      fault;
	} spfl_result_t;

endpackage

>>> hdl/spfl_check.sv
// ----------------------------------------------------------------------------
// spfl_check
// Window and step checks, clamping and bad run count update for one sample.
// ----------------------------------------------------------------------------
module spfl_check
	import spfl_pkg::*;
(
	input  spfl_sample_t       sample,
	input  spfl_hist_t         hist,
	input  spfl_cfg_t          cfg,
	input  logic [COUNT_W-1:0] count,
	output logic [COUNT_W-1:0] count_next,
	output spfl_result_t       result
);

	logic signed [EXT_W-1:0] dist_x, ego_x, tgt_x;
	logic signed [EXT_W-1:0] rmin_x, rmax_x, smax_x, dlim_x, slim_x;
	logic signed [EXT_W-1:0] d_diff, e_diff, t_diff;
	logic signed [EXT_W-1:0] d_lo, e_lo, t_lo, d_c, e_c, t_c;
	logic                    win_bad, step_bad, bad;
	logic [CMP_W-1:0]        cnt_x, fcyc_x;

	always_comb begin
		dist_x = EXT_W'(sample.distance);
		ego_x  = EXT_W'(sample.ego_speed);
		tgt_x  = EXT_W'(sample.target_speed);
		rmin_x = $signed(EXT_W'(cfg.dist_lo));
		rmax_x = $signed(EXT_W'(cfg.dist_hi));
		smax_x = $signed(EXT_W'(cfg.speed_max));
		dlim_x = $signed(EXT_W'(cfg.distance_step_max));
		slim_x = $signed(EXT_W'(cfg.speed_step_max));

		// sign bit marks a negative speed
		win_bad = (dist_x < rmin_x) || (dist_x > rmax_x) ||
			ego_x[EXT_W-1] || (ego_x > smax_x) ||
			tgt_x[EXT_W-1] || (tgt_x > smax_x);

		d_diff = dist_x - EXT_W'(hist.last_distance);
		e_diff = ego_x - EXT_W'(hist.last_ego_speed);
		t_diff = tgt_x - EXT_W'(hist.last_target_speed);
		// |diff| > lim, without taking the magnitude
		step_bad = !hist.first_sample && (
			(d_diff > dlim_x) || (d_diff < -dlim_x) ||
			(e_diff > slim_x) || (e_diff < -slim_x) ||
			(t_diff > slim_x) || (t_diff < -slim_x));

		bad = win_bad || step_bad;

		if (!bad)
			count_next = '0;
		else if (count == {COUNT_W{1'b1}})
			count_next = count;
		else
			count_next = count + 1'b1;

		// low bound first, then high bound: crossed window yields the high bound
		d_lo = (dist_x < rmin_x) ? rmin_x : dist_x;
		d_c  = (d_lo > rmax_x) ? rmax_x : d_lo;
		e_lo = ego_x[EXT_W-1] ? '0 : ego_x;
		e_c  = (e_lo > smax_x) ? smax_x : e_lo;
		t_lo = tgt_x[EXT_W-1] ? '0 : tgt_x;
		t_c  = (t_lo > smax_x) ? smax_x : t_lo;

		cnt_x  = CMP_W'(count_next);
		fcyc_x = CMP_W'(cfg.fault_cycles);

		result.distance       = d_c[LIMIT_W-1:0];
		result.ego_speed      = e_c[LIMIT_W-1:0];
		result.target_speed   = t_c[LIMIT_W-1:0];
		result.relative_speed = REL_W'(e_c[LIMIT_W-1:0]) - REL_W'(t_c[LIMIT_W-1:0]);
		result.pedal          = sample.pedal;
		result.steer          = sample.steer;
		result.fault          = (cnt_x >= fcyc_x);
	end

endmodule

>>> hdl/sensor_plausibility_fault_latch.sv
// ----------------------------------------------------------------------------
// sensor_plausibility_fault_latch
// Range and rate-of-change plausibility check with a saturating fault latch.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    distance_in .. steer_in
//  result    out_valid / out_ready  distance_out .. confidence
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A taken input request passes the input register, then the check logic into
//  the result register. One request per cycle sustained while out_ready is high.
//  Input stage advances whenever the result register is empty or being taken;
//  while a result is held, stage 1 takes at most one more request and in_ready
//  then stays low until the result is taken. cfg_ready is always high.
//  Reset restores register defaults, clears history and the bad run count.
// ----------------------------------------------------------------------------
module sensor_plausibility_fault_latch
	import spfl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] distance_in,
	input  logic signed [SAMPLE_W-1:0] ego_speed_in,
	input  logic signed [SAMPLE_W-1:0] target_speed_in,
	input  logic [PEDAL_W-1:0]         pedal_in,
	input  logic signed [STEER_W-1:0]  steer_in,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [LIMIT_W-1:0]         distance_out,
	output logic [LIMIT_W-1:0]         ego_speed_out,
	output logic [LIMIT_W-1:0]         target_speed_out,
	output logic signed [REL_W-1:0]    relative_speed,
	output logic [PEDAL_W-1:0]         pedal_out,
	output logic signed [STEER_W-1:0]  steer_out,
	output logic                       fault_flag,
	output logic                       confidence,

	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [LIMIT_W-1:0]         cfg_data
);

	spfl_cfg_t          cfg_q;
	spfl_hist_t         hist_q;
	logic [COUNT_W-1:0] count_q, count_next;
	spfl_sample_t       sample_s1;
	logic               valid_s1;
	spfl_result_t       result, result_q;
	logic               out_valid_q;
	logic               adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dist_lo           <= LIMIT_W'(128);
			cfg_q.dist_hi           <= LIMIT_W'(76800);
			cfg_q.speed_max         <= LIMIT_W'(12800);
			cfg_q.distance_step_max <= LIMIT_W'(2560);
			cfg_q.speed_step_max    <= LIMIT_W'(512);
			cfg_q.fault_cycles      <= FCYC_W'(3);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIST_LO:        cfg_q.dist_lo           <= cfg_data;
				REG_DIST_HI:        cfg_q.dist_hi           <= cfg_data;
				REG_SPEED_MAX:      cfg_q.speed_max         <= cfg_data;
				REG_DIST_STEP_MAX:  cfg_q.distance_step_max <= cfg_data;
				REG_SPEED_STEP_MAX: cfg_q.speed_step_max    <= cfg_data;
				REG_FAULT_CYCLES:   cfg_q.fault_cycles      <= cfg_data[FCYC_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1.distance     <= distance_in;
			sample_s1.ego_speed    <= ego_speed_in;
			sample_s1.target_speed <= target_speed_in;
			sample_s1.pedal        <= pedal_in;
			sample_s1.steer        <= steer_in;
		end
	end

	spfl_check u_check (
		.sample     (sample_s1),
		.hist       (hist_q),
		.cfg        (cfg_q),
		.count      (count_q),
		.count_next (count_next),
		.result     (result)
	);

	// history and counter move only when the sample leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '{default: '0, first_sample: 1'b1};
			count_q <= '0;
		end else if (adv_s1) begin
			hist_q.last_distance     <= sample_s1.distance;
			hist_q.last_ego_speed    <= sample_s1.ego_speed;
			hist_q.last_target_speed <= sample_s1.target_speed;
			hist_q.first_sample      <= 1'b0;
			count_q                  <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign distance_out     = result_q.distance;
	assign ego_speed_out    = result_q.ego_speed;
	assign target_speed_out = result_q.target_speed;
	assign relative_speed   = result_q.relative_speed;
	assign pedal_out        = result_q.pedal;
	assign steer_out        = result_q.steer;
	assign fault_flag       = result_q.fault;
	assign confidence       = !result_q.fault;

endmodule
